[rtl/assert_macros.svh]
// Assertion macros used by the reorder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/tsr_pkg.sv]
// Types and constants for the TCP segment reorder block.
package tsr_pkg;
   localparam int unsigned MIN_HDR_BYTES = 20;
   localparam logic [7:0] TCP_PROTO = 8'd6;

   typedef enum logic [2:0] {
      KIND_RELEASED = 3'd0,
      KIND_HELD     = 3'd1,
      KIND_STALE    = 3'd2,
      KIND_BAD_HDR  = 3'd3,
      KIND_NOT_TCP  = 3'd4,
      KIND_EMPTY    = 3'd5,
      KIND_FULL     = 3'd6
   } kind_type;

   // Header screening result handed to the reorder controller.
   typedef struct packed {
      logic     drop;
      kind_type kind;
      logic     syn;
      logic [15:0] len;
   } screen_type;
endpackage

[rtl/tsr_screen.sv]
// Header checks and payload length for one segment.
module tsr_screen (
   input  logic [3:0]  ip_header_words,
   input  logic [7:0]  ip_protocol,
   input  logic [15:0] ip_total_length,
   input  logic [3:0]  tcp_offset_words,
   input  logic        syn_flag,
   output tsr_pkg::screen_type screen
);
   import tsr_pkg::*;
   logic [5:0]  ip_bytes;
   logic [5:0]  tcp_bytes;
   logic [16:0] hdr_sum;
   always_comb begin
      ip_bytes  = {ip_header_words, 2'b00};
      tcp_bytes = {tcp_offset_words, 2'b00};
      hdr_sum   = 17'(ip_bytes) + 17'(tcp_bytes);
      screen.syn  = 1'b0;
      screen.drop = 1'b1;
      screen.kind = KIND_BAD_HDR;
      screen.len  = 16'(17'(ip_total_length) - hdr_sum);
      if (32'(ip_bytes) < MIN_HDR_BYTES) begin
         screen.kind = KIND_BAD_HDR;
      end else if (ip_protocol != TCP_PROTO) begin
         screen.kind = KIND_NOT_TCP;
      end else if (32'(tcp_bytes) < MIN_HDR_BYTES) begin
         screen.kind = KIND_BAD_HDR;
      end else begin
         screen.syn = syn_flag;
         if (17'(ip_total_length) == hdr_sum) begin
            screen.kind = KIND_EMPTY;
         end else if (17'(ip_total_length) < hdr_sum) begin
            screen.kind = KIND_BAD_HDR;
         end else begin
            screen.drop = 1'b0;
            screen.kind = KIND_RELEASED;
         end
      end
   end
endmodule

[rtl/tcp_segment_reorder.sv]
// Top level of the TCP segment reorder block: hold table memory and controller.
//
//  channel | ports                       | handshake
//  request | req_* fields, start, busy   | taken when start && !busy
//  result  | rsp_* fields, rsp_valid     | one-cycle strobe per result, no stall
//
// A drop answers in the cycle after acceptance and busy stays low.
// Any other segment scans all table entries, one memory read per cycle,
// then is held, stale or full, or is released; a release searches again for
// each chained segment, and ends with a final search that misses when the
// table held anything.
// Synchronous active-high reset clears expected sequence and valid bits.
// The receiver cannot stall; results are one-cycle strobes.
`include "assert_macros.svh"
module tcp_segment_reorder #(
   parameter int TABLE_DEPTH  = 16,
   parameter int HANDLE_WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [3:0]              req_ip_header_words,
   input  logic [7:0]              req_ip_protocol,
   input  logic [15:0]             req_ip_total_length,
   input  logic [3:0]              req_tcp_offset_words,
   input  logic                    req_syn_flag,
   input  logic [31:0]             req_sequence_number,
   input  logic [HANDLE_WIDTH-1:0] req_in_handle,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_result_kind,
   output logic [HANDLE_WIDTH-1:0] rsp_out_handle,
   output logic [31:0]             rsp_released_seq,
   output logic [15:0]             rsp_released_length,
   output logic                    rsp_last_of_run
);
   import tsr_pkg::*;
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EW = 48 + HANDLE_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_CHAIN, ST_CHAIN_WAIT
   } state_type;

   tsr_pkg::screen_type screen;
   tsr_screen u_screen (
      .ip_header_words (req_ip_header_words),
      .ip_protocol     (req_ip_protocol),
      .ip_total_length (req_ip_total_length),
      .tcp_offset_words(req_tcp_offset_words),
      .syn_flag        (req_syn_flag),
      .screen          (screen)
   );

   // entry = {seq, len, handle}
   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [HANDLE_WIDTH-1:0] hnd_ff, hnd_in;
   logic [IW:0] cnt_ff, cnt_in;       // issue index of the search
   logic [IW-1:0] rcnt_ff, rcnt_in;   // index of data now on rd_data_ff
   logic        rvld_ff, rvld_in;
   logic        hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [IW:0] nrel_ff, nrel_in;
   logic        out_v_in;
   logic [2:0]  out_k_ff, out_k_in;
   logic [HANDLE_WIDTH-1:0] out_h_ff, out_h_in;
   logic [31:0] out_s_ff, out_s_in;
   logic [15:0] out_l_ff, out_l_in;
   logic        out_last_in;

   logic [31:0] rd_seq;
   logic [15:0] rd_len;
   logic [HANDLE_WIDTH-1:0] rd_hnd;
   logic [31:0] eff_exp;
   logic        free_found;
   logic [IW-1:0] free_idx;
   logic        accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign {rd_seq, rd_len, rd_hnd} = rd_data_ff;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; exp_in = exp_ff;
      seq_in = seq_ff; len_in = len_ff; hnd_in = hnd_ff;
      cnt_in = cnt_ff; rcnt_in = rcnt_ff; rvld_in = 1'b0;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff; nrel_in = nrel_ff;
      out_v_in = 1'b0; out_k_in = out_k_ff; out_h_in = out_h_ff;
      out_s_in = out_s_ff; out_l_in = out_l_ff; out_last_in = 1'b0;
      rd_addr = cnt_ff[IW-1:0];
      wr_en = 1'b0; wr_addr = hit_idx_ff; wr_data = {seq_ff, len_ff, hnd_ff};
      eff_exp = exp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seq_in = req_sequence_number;
               len_in = screen.len;
               hnd_in = req_in_handle;
               if (screen.syn) begin
                  valid_in = '0;
                  exp_in   = '0;
               end
               if (screen.drop) begin
                  out_v_in = 1'b1; out_k_in = screen.kind; out_h_in = req_in_handle;
                  out_s_in = '0; out_l_in = '0; out_last_in = 1'b1;
               end else begin
                  eff_exp = screen.syn ? 32'd0 : exp_ff;
                  if (eff_exp == 32'd0) exp_in = req_sequence_number;
                  else exp_in = eff_exp;
                  cnt_in = '0; hit_in = 1'b0; nrel_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN, ST_CHAIN: begin
            // one entry read per cycle; compare the previous read
            if (rvld_ff && valid_ff[rcnt_ff] && rd_seq == seq_ff && !hit_ff) begin
               hit_in = 1'b1; hit_idx_in = rcnt_ff;
            end
            if (cnt_ff < (IW+1)'(TABLE_DEPTH)) begin
               rd_addr = cnt_ff[IW-1:0];
               rcnt_in = cnt_ff[IW-1:0];
               rvld_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else if (!rvld_ff) begin
               state_in = ST_DECIDE;
            end
            if (state_ff == ST_CHAIN && cnt_ff >= (IW+1)'(TABLE_DEPTH) && !rvld_ff)
               state_in = ST_CHAIN_WAIT;
         end
         ST_DECIDE: begin
            out_v_in = 1'b1; out_h_in = hnd_ff; out_s_in = seq_ff; out_l_in = len_ff;
            if (seq_ff < exp_ff) begin
               out_k_in = KIND_STALE; out_last_in = 1'b1; state_in = ST_IDLE;
            end else if (seq_ff > exp_ff) begin
               out_last_in = 1'b1; state_in = ST_IDLE;
               if (hit_ff || free_found) begin
                  wr_en = 1'b1; wr_addr = hit_ff ? hit_idx_ff : free_idx;
                  valid_in[wr_addr] = 1'b1;
                  out_k_in = KIND_HELD;
               end else begin
                  out_k_in = KIND_FULL;
               end
            end else begin
               out_k_in = KIND_RELEASED;
               exp_in = exp_ff + 32'(len_ff);
               nrel_in = '0;
               if (valid_ff == '0) begin
                  out_last_in = 1'b1; state_in = ST_IDLE;
               end else begin
                  seq_in = exp_ff + 32'(len_ff);
                  cnt_in = '0; hit_in = 1'b0; state_in = ST_CHAIN;
               end
            end
         end
         ST_CHAIN_WAIT: begin
            // search for expected done; read the hit entry
            rd_addr = hit_idx_ff;
            if (!hit_ff || nrel_ff >= (IW+1)'(TABLE_DEPTH)) begin
               // no chain link or release limit reached: flag last on an extra
               // beat is not allowed, so last was deferred; emit pending result now
               state_in = ST_IDLE;
            end else if (!rvld_ff) begin
               rvld_in = 1'b1; rcnt_in = hit_idx_ff;
            end else begin
               valid_in[hit_idx_ff] = 1'b0;
               nrel_in  = nrel_ff + 1'b1;
               out_v_in = 1'b1; out_k_in = KIND_RELEASED;
               out_h_in = rd_hnd; out_s_in = rd_seq; out_l_in = rd_len;
               exp_in = exp_ff + 32'(rd_len);
               seq_in = exp_ff + 32'(rd_len);
               cnt_in = '0; hit_in = 1'b0; state_in = ST_CHAIN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A result is held back until the next one or the end of the run, so that last_of_run can be set on the final one.
   logic        pend_ff;
   logic        fin;
   assign fin = (state_ff == ST_CHAIN_WAIT) && (!hit_ff || nrel_ff >= (IW+1)'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; exp_ff <= '0;
         rvld_ff <= 1'b0; pend_ff <= 1'b0; rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; exp_ff <= exp_in;
         rvld_ff  <= rvld_in;
         // a release with chain pending is parked in out_* until the next one
         if (out_v_in) begin
            if (pend_ff) rsp_valid <= 1'b1; else rsp_valid <= out_last_in;
            pend_ff <= !out_last_in;
         end else begin
            rsp_valid <= fin && pend_ff;
            if (fin) pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in; len_ff <= len_in; hnd_ff <= hnd_in;
      cnt_ff <= cnt_in; rcnt_ff <= rcnt_in; hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in; nrel_ff <= nrel_in;
      if (out_v_in) begin
         out_k_ff <= out_k_in; out_h_ff <= out_h_in;
         out_s_ff <= out_s_in; out_l_ff <= out_l_in;
         if (pend_ff) begin
            rsp_result_kind <= out_k_ff; rsp_out_handle <= out_h_ff;
            rsp_released_seq <= out_s_ff; rsp_released_length <= out_l_ff;
            rsp_last_of_run <= 1'b0;
         end else begin
            rsp_result_kind <= out_k_in; rsp_out_handle <= out_h_in;
            rsp_released_seq <= out_s_in; rsp_released_length <= out_l_in;
            rsp_last_of_run <= out_last_in;
         end
      end else if (fin) begin
         rsp_result_kind <= out_k_ff; rsp_out_handle <= out_h_ff;
         rsp_released_seq <= out_s_ff; rsp_released_length <= out_l_ff;
         rsp_last_of_run <= 1'b1;
      end
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, accept && !screen.drop, busy,
      "busy not raised after accepted segment")
   `ASSERT_IMPLIES(a_idle_rsp, clock, reset, rsp_valid && rsp_last_of_run,
      !pend_ff, "pending result left after last")
   `ASSERT_NEXT(a_hold_sets, clock, reset,
      wr_en, valid_ff != '0, "held write left no valid entry")
endmodule

[tb/tb.sv]
// Self-checking testbench for the TCP segment reorder block.
`timescale 1ns / 100ps
module tb;
   import tsr_pkg::*;

   localparam int HOLD_DEPTH = 16;
   localparam int IDLE_LIMIT = 4000;   // cycles with no transaction on either side
   localparam int TAIL_CYCLES = 400;   // covers the longest chained release
   localparam int RANDOM_ITEMS = 95;

   // One captured segment as presented on the request side.
   typedef struct {
      logic [3:0]  ihl;
      logic [7:0]  proto;
      logic [15:0] total;
      logic [3:0]  tcp_words;
      logic        syn;
      logic [31:0] seq;
      logic [7:0]  handle;
      bit          drain;   // sender holds off until all results are back
   } segment_type;

   // One predicted result.
   typedef struct {
      kind_type    kind;
      logic [7:0]  handle;
      logic [31:0] seq;
      logic [15:0] length;
      logic        last;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_ip_header_words = '0;
   logic [7:0]  req_ip_protocol = '0;
   logic [15:0] req_ip_total_length = '0;
   logic [3:0]  req_tcp_offset_words = '0;
   logic        req_syn_flag = 1'b0;
   logic [31:0] req_sequence_number = '0;
   logic [7:0]  req_in_handle = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_result_kind;
   logic [7:0]  rsp_out_handle;
   logic [31:0] rsp_released_seq;
   logic [15:0] rsp_released_length;
   logic        rsp_last_of_run;

   tcp_segment_reorder #(.TABLE_DEPTH(HOLD_DEPTH), .HANDLE_WIDTH(8)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ip_header_words(req_ip_header_words),
      .req_ip_protocol(req_ip_protocol),
      .req_ip_total_length(req_ip_total_length),
      .req_tcp_offset_words(req_tcp_offset_words),
      .req_syn_flag(req_syn_flag),
      .req_sequence_number(req_sequence_number),
      .req_in_handle(req_in_handle),
      .rsp_valid(rsp_valid),
      .rsp_result_kind(rsp_result_kind),
      .rsp_out_handle(rsp_out_handle),
      .rsp_released_seq(rsp_released_seq),
      .rsp_released_length(rsp_released_length),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Reorder predictor: own copy of the expected sequence and the hold
   // table. Runs once per accepted segment and queues its results.
   // ---------------------------------------------------------------
   logic [31:0] next_seq;
   bit          held_valid [HOLD_DEPTH];
   logic [31:0] held_seq   [HOLD_DEPTH];
   logic [15:0] held_len   [HOLD_DEPTH];
   logic [7:0]  held_handle[HOLD_DEPTH];
   verdict_type verdict_q[$];

   segment_type segment_q[$];   // segments not yet presented
   segment_type cur_segment;    // segment currently on the request ports

   int unsigned segments_taken = 0;
   int unsigned total_segments = 0;
   int unsigned results_seen = 0;
   int unsigned releases_seen = 0;
   int unsigned mismatches = 0;

   function automatic void queue_verdict(kind_type kind, logic [7:0] handle,
                                         logic [31:0] seq, logic [15:0] length);
      verdict_type v;
      v.kind = kind;
      v.handle = handle;
      v.seq = seq;
      v.length = length;
      v.last = 1'b0;
      verdict_q.push_back(v);
   endfunction

   function automatic int lookup_held(logic [31:0] seq);
      for (int i = 0; i < HOLD_DEPTH; i++)
         if (held_valid[i] && held_seq[i] == seq) return i;
      return -1;
   endfunction

   function automatic void reorder_segment(segment_type s);
      int unsigned ip_bytes;
      int unsigned tcp_bytes;
      logic [15:0] len;
      int          slot;
      int          chained;
      ip_bytes = s.ihl * 4;
      tcp_bytes = s.tcp_words * 4;
      chained = 0;
      // screening order: IP header, protocol, TCP header
      if (ip_bytes < MIN_HDR_BYTES) queue_verdict(KIND_BAD_HDR, s.handle, '0, '0);
      else if (s.proto != TCP_PROTO) queue_verdict(KIND_NOT_TCP, s.handle, '0, '0);
      else if (tcp_bytes < MIN_HDR_BYTES) queue_verdict(KIND_BAD_HDR, s.handle, '0, '0);
      else begin
         // SYN wipes state before the payload length is even looked at
         if (s.syn) begin
            next_seq = '0;
            foreach (held_valid[i]) held_valid[i] = 1'b0;
         end
         if (s.total == ip_bytes + tcp_bytes) queue_verdict(KIND_EMPTY, s.handle, '0, '0);
         else if (s.total < ip_bytes + tcp_bytes)
            queue_verdict(KIND_BAD_HDR, s.handle, '0, '0);
         else begin
            len = 16'(s.total - ip_bytes - tcp_bytes);
            if (next_seq == '0) next_seq = s.seq;   // unset: adopt this segment
            if (s.seq < next_seq) queue_verdict(KIND_STALE, s.handle, s.seq, len);
            else if (s.seq > next_seq) begin
               slot = lookup_held(s.seq);
               if (slot < 0)
                  for (int i = HOLD_DEPTH - 1; i >= 0; i--)
                     if (!held_valid[i]) slot = i;   // lowest free entry wins
               if (slot < 0) queue_verdict(KIND_FULL, s.handle, s.seq, len);
               else begin
                  held_valid[slot] = 1'b1;
                  held_seq[slot] = s.seq;
                  held_len[slot] = len;
                  held_handle[slot] = s.handle;
                  queue_verdict(KIND_HELD, s.handle, s.seq, len);
               end
            end else begin
               queue_verdict(KIND_RELEASED, s.handle, s.seq, len);
               next_seq = next_seq + len;
               // drain whatever now follows on in order
               while (chained < HOLD_DEPTH) begin
                  slot = lookup_held(next_seq);
                  if (slot < 0) break;
                  held_valid[slot] = 1'b0;
                  queue_verdict(KIND_RELEASED, held_handle[slot], held_seq[slot],
                                held_len[slot]);
                  next_seq = next_seq + held_len[slot];
                  chained++;
               end
            end
         end
      end
      verdict_q[verdict_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Driver: presents queued segments with random gaps between them,
   // with burst stretches where the gap is always zero.
   // ---------------------------------------------------------------
   int unsigned gap_left = 0;
   bit          burst_mode = 1'b0;

   function automatic int unsigned draw_gap();
      if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
      return burst_mode ? 0 : $urandom_range(0, 5);
   endfunction

   task automatic present(segment_type s);
      cur_segment = s;
      req_ip_header_words <= s.ihl;
      req_ip_protocol <= s.proto;
      req_ip_total_length <= s.total;
      req_tcp_offset_words <= s.tcp_words;
      req_syn_flag <= s.syn;
      req_sequence_number <= s.seq;
      req_in_handle <= s.handle;
   endtask

   function automatic bit may_present();
      return segment_q.size() > 0 && !(segment_q[0].drain && verdict_q.size() > 0);
   endfunction

   always @(posedge clock) begin
      int unsigned g;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         // transaction accepted at this edge
         reorder_segment(cur_segment);
         segments_taken++;
         g = draw_gap();
         if (g == 0 && may_present()) present(segment_q.pop_front());
         else begin
            start <= 1'b0;
            gap_left <= g;
         end
      end else if (!start) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (may_present()) begin
            present(segment_q.pop_front());
            start <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: every strobe is checked against the oldest prediction.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_result_kind == KIND_RELEASED) releases_seen++;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result kind=%0d handle=%0d seq=%h len=%0d",
                        $realtime, rsp_result_kind, rsp_out_handle, rsp_released_seq,
                        rsp_released_length);
         end else begin
            v = verdict_q.pop_front();
            if (rsp_result_kind !== v.kind || rsp_out_handle !== v.handle ||
                rsp_released_seq !== v.seq || rsp_released_length !== v.length ||
                rsp_last_of_run !== v.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch exp kind=%0d handle=%0d seq=%h len=%0d last=%0b",
                           $realtime, v.kind, v.handle, v.seq, v.length, v.last);
                  $display("    got kind=%0d handle=%0d seq=%h len=%0d last=%0b",
                           rsp_result_kind, rsp_out_handle, rsp_released_seq,
                           rsp_released_length, rsp_last_of_run);
               end
            end
         end
      end
   end

   // Watchdog: too long without a transaction on either side.
   int unsigned idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic segment_type raw_segment(logic [3:0] ihl, logic [7:0] proto,
                                               logic [15:0] total, logic [3:0] tcp_words,
                                               logic syn, logic [31:0] seq,
                                               logic [7:0] handle);
      segment_type s;
      s.ihl = ihl;
      s.proto = proto;
      s.total = total;
      s.tcp_words = tcp_words;
      s.syn = syn;
      s.seq = seq;
      s.handle = handle;
      s.drain = 1'b0;
      return s;
   endfunction

   // Well-formed TCP segment, header sizes drawn at random.
   function automatic segment_type tcp_segment(logic [31:0] seq, int unsigned len,
                                               logic syn);
      logic [3:0] ihl;
      logic [3:0] tw;
      ihl = 4'($urandom_range(5, 15));
      tw = 4'($urandom_range(5, 15));
      return raw_segment(ihl, TCP_PROTO, 16'(ihl * 4 + tw * 4 + len), tw, syn, seq,
                         8'($urandom));
   endfunction

   function automatic segment_type noise_segment();
      return raw_segment(4'($urandom), ($urandom_range(0, 1) ? TCP_PROTO : 8'($urandom)),
                         16'($urandom), 4'($urandom), 1'($urandom), $urandom,
                         8'($urandom));
   endfunction

   task automatic build_directed();
      logic [31:0] base;
      // screening in order, plus the extreme header encodings
      segment_q.push_back(raw_segment(4'd0, 8'd0, 16'd0, 4'd0, 1'b0, 32'd0, 8'd0));
      segment_q.push_back(raw_segment(4'd4, TCP_PROTO, 16'd100, 4'd5, 1'b0, 32'd1, 8'd1));
      segment_q.push_back(raw_segment(4'd5, 8'd17, 16'd100, 4'd5, 1'b0, 32'd1, 8'd2));
      segment_q.push_back(raw_segment(4'd5, 8'd255, 16'd100, 4'd0, 1'b0, 32'd1, 8'd3));
      segment_q.push_back(raw_segment(4'd15, TCP_PROTO, 16'd100, 4'd4, 1'b0, 32'd1, 8'd4));
      // empty payload, then headers longer than the packet
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd40, 4'd5, 1'b0, 32'd1, 8'd5));
      segment_q.push_back(raw_segment(4'd15, TCP_PROTO, 16'd119, 4'd15, 1'b0, 32'd1, 8'd6));
      // SYN adopts its own sequence and releases at once
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd140, 4'd5, 1'b1, 32'd1000,
                                      8'd255));
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd60, 4'd5, 1'b0, 32'd500, 8'd7));
      // hold, overwrite the same key, then fill the gap: chain of two
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd50, 4'd5, 1'b0, 32'd1200, 8'd8));
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd65535, 4'd5, 1'b0, 32'd1200,
                                      8'd9));
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd140, 4'd5, 1'b0, 32'd1100,
                                      8'd10));
      // SYN that is then dropped as empty still clears the state
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd40, 4'd5, 1'b1, 32'd77, 8'd11));
      // near the top of sequence space: fill the table, overflow, full chain
      // whose final advance wraps the expected value back to unset
      base = 32'hFFFF_FEF0;
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd56, 4'd5, 1'b1, base - 16,
                                      8'd12));
      for (int i = HOLD_DEPTH; i >= 1; i--)
         segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd56, 4'd5, 1'b0,
                                         base + 16 * i, 8'(20 + i)));
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd56, 4'd5, 1'b0, 32'hFFFF_FFFF,
                                      8'd40));
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd56, 4'd5, 1'b0, base, 8'd41));
      segment_q[segment_q.size() - 1].drain = 1'b1;
      segment_q.push_back(raw_segment(4'd5, TCP_PROTO, 16'd41, 4'd5, 1'b0, 32'd5, 8'd42));
   endtask

   // Mostly connection-like groups: in-order runs shuffled, with duplicates
   // and stale repeats; the rest is noise over the full field ranges.
   task automatic build_random();
      logic [31:0] run_next;
      segment_type grp[$];
      segment_type tmp;
      int unsigned len;
      int unsigned count;
      int          j;
      count = 0;
      run_next = $urandom | 32'd1;
      while (count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            segment_q.push_back(noise_segment());
            count++;
         end else begin
            grp.delete();
            if ($urandom_range(0, 3) == 0) begin
               len = $urandom_range(1, 1400);
               run_next = $urandom | 32'd1;
               segment_q.push_back(tcp_segment(run_next, len, 1'b1));
               run_next += len;
               count++;
            end
            repeat ($urandom_range(1, 6)) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65415)
                                                 : $urandom_range(1, 1400);
               grp.push_back(tcp_segment(run_next, len, 1'b0));
               run_next += len;
            end
            if ($urandom_range(0, 3) == 0) grp.push_back(grp[$urandom_range(0, grp.size()-1)]);
            if ($urandom_range(0, 4) == 0)
               grp.push_back(tcp_segment(grp[0].seq - $urandom_range(1, 3000),
                                         $urandom_range(1, 500), 1'b0));
            for (int i = grp.size() - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = grp[i];
               grp[i] = grp[j];
               grp[j] = tmp;
            end
            if ($urandom_range(0, 7) == 0) grp[0].drain = 1'b1;
            foreach (grp[i]) segment_q.push_back(grp[i]);
            count += grp.size();
         end
      end
   endtask

   initial begin
      next_seq = '0;
      foreach (held_valid[i]) held_valid[i] = 1'b0;
      build_directed();
      build_random();
      total_segments = segment_q.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // all segments taken, then every result back
      wait (segments_taken == total_segments && verdict_q.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d segments, %0d results checked, %0d of them releases.",
               segments_taken, results_seen, releases_seen);
      $display("Mismatches: %0d, predictions left over: %0d.", mismatches,
               verdict_q.size());
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
